FILE: hdl/smx_pkg.sv
// Shared types, constants and exponential tables for the softmax normalizer.
package smx_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int Q56_W       = 57;
    localparam int EXP_W       = 17;
    localparam int SUM_W       = 23;
    localparam int PROD_W      = 2 * Q56_W;
    localparam logic [3:0] EXP_ZERO_IP = 4'd12;

    typedef logic [Q56_W-1:0] t_q56;
    typedef t_q56 t_frac_tbl [256];

    typedef enum logic [8:0] {
        ST_LOAD = 9'b000000001,
        ST_RD   = 9'b000000010,
        ST_EXP  = 9'b000000100,
        ST_MUL  = 9'b000001000,
        ST_EWR  = 9'b000010000,
        ST_DRD  = 9'b000100000,
        ST_DST  = 9'b001000000,
        ST_DIV  = 9'b010000000,
        ST_OUT  = 9'b100000000
    } t_state;

    // Shift-and-subtract quotient, used only while the constant tables are built.
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], a[i]};
            if (r >= 65'(b)) begin
                r    = r - 65'(b);
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_q56 exp_frac(input logic [7:0] num);
        logic [63:0] t;
        logic [63:0] s;
        t = 64'd1 << 56;
        s = 64'd1 << 56;
        for (int n = 1; n <= 24; n++) begin
            t = udiv64(t * 64'(num), 64'd256 * 64'(n));
            if (n[0]) begin
                s = s - t;
            end else begin
                s = s + t;
            end
        end
        return s[Q56_W-1:0];
    endfunction

    function automatic t_frac_tbl build_frac_tbl();
        t_frac_tbl tbl;
        for (int f = 0; f < 256; f++) begin
            tbl[f] = exp_frac(8'(f));
        end
        return tbl;
    endfunction

    function automatic t_q56 mul_q56(input t_q56 a, input t_q56 b);
        logic [PROD_W-1:0] p;
        p = PROD_W'(a) * PROD_W'(b);
        return p[56 +: Q56_W];
    endfunction

    localparam t_frac_tbl FRAC_TBL = build_frac_tbl();
    localparam t_q56      E_INV    = mul_q56(exp_frac(8'd128), exp_frac(8'd128));

endpackage

FILE: hdl/smx_in_if.sv
// Input channel carrying one logit item.
interface smx_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] logit;
    logic               last_in;

    modport source (output valid, output logit, output last_in, input ready);
    modport sink   (input valid, input logit, input last_in, output ready);
endinterface

FILE: hdl/smx_out_if.sv
// Output channel carrying one probability item.
interface smx_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] probability;
    logic        last_out;
    logic        truncated;

    modport source (output valid, output probability, output last_out, output truncated,
                    input ready);
    modport sink   (input valid, input probability, input last_out, input truncated,
                    output ready);
endinterface

FILE: hdl/smx_mul.sv
// Iterative Q1.56 multiplier built on one shared 32x32 multiplier.
module smx_mul (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  smx_pkg::t_q56        i_a,
    input  smx_pkg::t_q56        i_b,
    output logic                 o_done,
    output smx_pkg::t_q56        o_p
);
    logic [smx_pkg::Q56_W-1:0]  r_a, r_b;
    logic [smx_pkg::PROD_W-1:0] r_acc;
    logic [63:0]                r_prod;
    logic [1:0]                 r_psel;
    logic [2:0]                 r_cnt;
    logic                       r_busy, r_done;
    logic [31:0]                w_x, w_y;
    logic [smx_pkg::PROD_W-1:0] w_add;

    always_comb begin
        unique case (r_cnt[1:0])
            2'd0: begin w_x = r_a[31:0];          w_y = r_b[31:0];          end
            2'd1: begin w_x = r_a[31:0];          w_y = 32'(r_b[56:32]);    end
            2'd2: begin w_x = 32'(r_a[56:32]);    w_y = r_b[31:0];          end
            default: begin w_x = 32'(r_a[56:32]); w_y = 32'(r_b[56:32]);    end
        endcase
        unique case (r_psel)
            2'd0:    w_add = smx_pkg::PROD_W'(r_prod);
            2'd3:    w_add = smx_pkg::PROD_W'(r_prod) << 64;
            default: w_add = smx_pkg::PROD_W'(r_prod) << 32;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_cnt != 3'd4) begin
                    r_prod <= 64'(w_x) * 64'(w_y);
                    r_psel <= r_cnt[1:0];
                end
                if (r_cnt != 3'd0) begin
                    r_acc <= r_acc + w_add;
                end
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc[56 +: smx_pkg::Q56_W];
endmodule

FILE: hdl/smx_div.sv
// Restoring divider that forms the saturated Q0.16 probability one bit per cycle.
module smx_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [smx_pkg::EXP_W-1:0] i_num,
    input  logic [smx_pkg::SUM_W-1:0] i_den,
    output logic                      o_done,
    output logic [15:0]               o_q
);
    logic [32:0]               r_n;
    logic [smx_pkg::SUM_W:0]   r_rem;
    logic [17:0]               r_q;
    logic [smx_pkg::SUM_W-1:0] r_den;
    logic [5:0]                r_cnt;
    logic                      r_busy, r_done;
    logic [smx_pkg::SUM_W:0]   w_trial;
    logic                      w_ge;

    assign w_trial = {r_rem[smx_pkg::SUM_W-1:0], r_n[32]};
    assign w_ge    = w_trial >= (smx_pkg::SUM_W + 1)'(r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_n    <= {i_num, 16'd0};
                r_rem  <= '0;
                r_q    <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_n   <= {r_n[31:0], 1'b0};
                r_rem <= w_ge ? w_trial - (smx_pkg::SUM_W + 1)'(r_den) : w_trial;
                r_q   <= {r_q[16:0], w_ge};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd32) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = (r_den == '0) ? 16'd0 : ((r_q[17:16] != 2'd0) ? 16'hFFFF : r_q[15:0]);
endmodule

FILE: hdl/softmax_normalizer.sv
// Top level of the softmax normalizer: vector stores, sequencer and shared units.
//   channel | direction | fields
//   i_in    | sink      | logit (signed Q8.8), last_in
//   o_out   | source    | probability (Q0.16), last_out, truncated
// Loading accepts one item per cycle. After the last item each element forms
// its exponential from a table value and one multiply by e^-1 per integer
// step (up to 11), then is divided in the bit-serial divider and waits for o_out.ready.
// The input is not ready during the compute and output phases.
// Reset is synchronous and active low; the stores are not cleared.
module softmax_normalizer #(
    parameter int MAX_LEN = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    smx_in_if.sink       i_in,
    smx_out_if.source    o_out
);
    smx_pkg::t_state               r_state, n_state;
    logic [15:0]                   r_lmem [smx_pkg::STORE_DEPTH];
    logic [smx_pkg::EXP_W-1:0]     r_emem [smx_pkg::STORE_DEPTH];
    logic [15:0]                   r_lrd;
    logic [smx_pkg::EXP_W-1:0]     r_erd;
    logic [smx_pkg::CNT_W-1:0]     r_count;
    logic signed [15:0]            r_max;
    logic [smx_pkg::SUM_W-1:0]     r_sum;
    logic                          r_ovf;
    logic [smx_pkg::IDX_W-1:0]     r_idx;
    smx_pkg::t_q56                 r_v;
    logic [3:0]                    r_ip;
    logic                          r_zero;
    logic [15:0]                   r_prob;
    logic                          r_last;

    logic                          w_acc, w_room, w_end;
    logic [15:0]                   w_k;
    logic                          mul_start, mul_done, div_done;
    smx_pkg::t_q56                 mul_a, mul_p;
    logic [15:0]                   div_q;
    logic [56:0]                   w_round;
    logic [smx_pkg::EXP_W-1:0]     w_e;

    assign i_in.ready = (r_state == smx_pkg::ST_LOAD);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_room     = r_count < smx_pkg::CNT_W'(MAX_LEN);
    assign w_end      = (smx_pkg::CNT_W'(r_idx) == r_count - smx_pkg::CNT_W'(1));
    assign w_k        = 16'(r_max - $signed(r_lrd));
    assign w_round    = r_v + (57'd1 << 39);
    assign w_e        = r_zero ? '0 : w_round[56:40];

    always_comb begin
        mul_start = 1'b0;
        mul_a     = smx_pkg::FRAC_TBL[w_k[7:0]];
        if (r_state == smx_pkg::ST_EXP) begin
            mul_start = (w_k[15:8] < 8'(smx_pkg::EXP_ZERO_IP)) && (w_k[15:8] != 8'd0);
        end else if (r_state == smx_pkg::ST_MUL) begin
            mul_a     = mul_p;
            mul_start = mul_done && (r_ip != 4'd1);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            smx_pkg::ST_LOAD: if (w_acc && i_in.last_in) n_state = smx_pkg::ST_RD;
            smx_pkg::ST_RD:   n_state = smx_pkg::ST_EXP;
            smx_pkg::ST_EXP:  n_state = mul_start ? smx_pkg::ST_MUL : smx_pkg::ST_EWR;
            smx_pkg::ST_MUL:  if (mul_done && r_ip == 4'd1) n_state = smx_pkg::ST_EWR;
            smx_pkg::ST_EWR:  n_state = w_end ? smx_pkg::ST_DRD : smx_pkg::ST_RD;
            smx_pkg::ST_DRD:  n_state = smx_pkg::ST_DST;
            smx_pkg::ST_DST:  n_state = smx_pkg::ST_DIV;
            smx_pkg::ST_DIV:  if (div_done) n_state = smx_pkg::ST_OUT;
            smx_pkg::ST_OUT: begin
                if (o_out.ready) n_state = w_end ? smx_pkg::ST_LOAD : smx_pkg::ST_DRD;
            end
            default:          n_state = smx_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_room) begin
            r_lmem[r_count[smx_pkg::IDX_W-1:0]] <= i_in.logit;
        end
        if (r_state == smx_pkg::ST_RD) begin
            r_lrd <= r_lmem[r_idx];
        end
        if (r_state == smx_pkg::ST_EWR) begin
            r_emem[r_idx] <= w_e;
        end
        if (r_state == smx_pkg::ST_DRD) begin
            r_erd <= r_emem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smx_pkg::ST_LOAD;
            r_count <= '0;
            r_max   <= 16'sh8000;
            r_sum   <= '0;
            r_ovf   <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                smx_pkg::ST_LOAD: begin
                    if (w_acc) begin
                        if (w_room) begin
                            r_count <= r_count + smx_pkg::CNT_W'(1);
                            if (i_in.logit > r_max) r_max <= i_in.logit;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        r_idx <= '0;
                        r_sum <= '0;
                    end
                end
                smx_pkg::ST_EXP: begin
                    r_v    <= smx_pkg::FRAC_TBL[w_k[7:0]];
                    r_ip   <= w_k[11:8];
                    r_zero <= w_k[15:8] >= 8'(smx_pkg::EXP_ZERO_IP);
                end
                smx_pkg::ST_MUL: begin
                    if (mul_done) begin
                        r_v  <= mul_p;
                        r_ip <= r_ip - 4'd1;
                    end
                end
                smx_pkg::ST_EWR: begin
                    r_sum <= r_sum + smx_pkg::SUM_W'(w_e);
                    r_idx <= w_end ? '0 : r_idx + smx_pkg::IDX_W'(1);
                end
                smx_pkg::ST_DIV: begin
                    if (div_done) begin
                        r_prob <= div_q;
                        r_last <= w_end;
                    end
                end
                smx_pkg::ST_OUT: begin
                    if (o_out.ready) begin
                        if (w_end) begin
                            r_count <= '0;
                            r_max   <= 16'sh8000;
                            r_sum   <= '0;
                            r_ovf   <= 1'b0;
                            r_idx   <= '0;
                        end else begin
                            r_idx <= r_idx + smx_pkg::IDX_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    smx_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (smx_pkg::E_INV),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    smx_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == smx_pkg::ST_DST),
        .i_num   (r_erd),
        .i_den   (r_sum),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    assign o_out.valid       = (r_state == smx_pkg::ST_OUT);
    assign o_out.probability = r_prob;
    assign o_out.last_out    = r_last;
    assign o_out.truncated   = r_ovf;
endmodule
